// ===== rtl/core/mwo_pkg.sv =====
// Package: shared types, constants and lookup tables for the oscillator.
`default_nettype none
package mwo_pkg;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_GAIN    = 2'd2;

    localparam logic [1:0] SHAPE_SINE     = 2'd0;
    localparam logic [1:0] SHAPE_SQUARE   = 2'd1;
    localparam logic [1:0] SHAPE_SAWTOOTH = 2'd2;
    localparam logic [1:0] SHAPE_TRIANGLE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MOD,
        ST_DIV,
        ST_SHAPE,
        ST_CLIP,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mul_step;
        logic mod_step;
        logic div_step;
        logic shape;
        logic clip;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic mul_done;
        logic mod_done;
        logic div_done;
    } t_status;

    function automatic logic [15:0] sine_tab(input logic [5:0] i);
        logic [15:0] v;
        v = 16'd0;
        unique case (i)
            6'd0: v = 16'd0;      6'd1: v = 16'd1608;   6'd2: v = 16'd3212;
            6'd3: v = 16'd4808;   6'd4: v = 16'd6393;   6'd5: v = 16'd7962;
            6'd6: v = 16'd9512;   6'd7: v = 16'd11039;  6'd8: v = 16'd12540;
            6'd9: v = 16'd14010;  6'd10: v = 16'd15447; 6'd11: v = 16'd16846;
            6'd12: v = 16'd18205; 6'd13: v = 16'd19520; 6'd14: v = 16'd20788;
            6'd15: v = 16'd22006; 6'd16: v = 16'd23170; 6'd17: v = 16'd24279;
            6'd18: v = 16'd25330; 6'd19: v = 16'd26320; 6'd20: v = 16'd27246;
            6'd21: v = 16'd28106; 6'd22: v = 16'd28899; 6'd23: v = 16'd29622;
            6'd24: v = 16'd30274; 6'd25: v = 16'd30853; 6'd26: v = 16'd31357;
            6'd27: v = 16'd31786; 6'd28: v = 16'd32138; 6'd29: v = 16'd32413;
            6'd30: v = 16'd32610; 6'd31: v = 16'd32729; 6'd32: v = 16'd32768;
            default: v = 16'd32768;
        endcase
        return v;
    endfunction

    function automatic logic [14:0] tanh_tab(input logic [5:0] i);
        logic [14:0] v;
        v = 15'd32767;
        unique case (i)
            6'd0: v = 15'd0;      6'd1: v = 15'd4075;   6'd2: v = 15'd8025;
            6'd3: v = 15'd11743;  6'd4: v = 15'd15143;  6'd5: v = 15'd18173;
            6'd6: v = 15'd20813;  6'd7: v = 15'd23066;  6'd8: v = 15'd24956;
            6'd9: v = 15'd26520;  6'd10: v = 15'd27797; 6'd11: v = 15'd28830;
            6'd12: v = 15'd29660; 6'd13: v = 15'd30322; 6'd14: v = 15'd30847;
            6'd15: v = 15'd31262; 6'd16: v = 15'd31589; 6'd17: v = 15'd31846;
            6'd18: v = 15'd32048; 6'd19: v = 15'd32206; 6'd20: v = 15'd32329;
            6'd21: v = 15'd32426; 6'd22: v = 15'd32501; 6'd23: v = 15'd32560;
            6'd24: v = 15'd32606; 6'd25: v = 15'd32642; 6'd26: v = 15'd32670;
            6'd27: v = 15'd32691; 6'd28: v = 15'd32708; 6'd29: v = 15'd32721;
            6'd30: v = 15'd32732; 6'd31: v = 15'd32740; 6'd32: v = 15'd32746;
            6'd33: v = 15'd32751; 6'd34: v = 15'd32755; 6'd35: v = 15'd32758;
            6'd36: v = 15'd32760; 6'd37: v = 15'd32762; 6'd38: v = 15'd32763;
            6'd39: v = 15'd32764; 6'd40: v = 15'd32765; 6'd41: v = 15'd32766;
            6'd42: v = 15'd32766; 6'd43: v = 15'd32767; 6'd44: v = 15'd32767;
            default: v = 15'd32767;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/mwo_ctrl.sv =====
// Controller: sequences load, multiply, reduce, divide, shape, clip and output.
`default_nettype none
module mwo_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  mwo_pkg::t_status i_status,
    output mwo_pkg::t_cmd    o_cmd
);
    import mwo_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_done) n_state = ST_MOD;
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_done) n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = ST_SHAPE;
            end
            ST_SHAPE: begin
                o_cmd.shape = 1'b1;
                n_state     = ST_CLIP;
            end
            ST_CLIP: begin
                o_cmd.clip = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                // result word sits in the output register until taken
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
                if (i_out_ready) begin
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_MUL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/mwo_dp.sv =====
// Datapath: index, shift-add multiply, modular reduction, phase divide, wave, tanh.
`default_nettype none
module mwo_dp #(
    parameter int INDEX_BITS  = 32,
    parameter int PHASE_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  mwo_pkg::t_cmd           i_cmd,
    output mwo_pkg::t_status        o_status,
    input  wire [31:0]              i_frequency,
    input  wire                     i_first,
    input  wire [1:0]               i_wave_shape,
    input  wire [17:0]              i_sample_rate,
    input  wire [15:0]              i_amp_gain,
    output logic [SAMPLE_BITS-1:0]  o_sample
);
    import mwo_pkg::*;

    localparam int MW    = 26;               // modulus width: 256*rate
    localparam int PW    = 32 + INDEX_BITS;  // product width
    localparam int MCW   = $clog2(PW + 1);
    localparam int DCW   = $clog2(PHASE_BITS + 1);
    localparam int SH    = PHASE_BITS - 15;

    logic [INDEX_BITS-1:0] r_index;
    logic [INDEX_BITS-1:0] r_idx;
    logic [31:0]           r_freq;
    logic [MW-1:0]         r_m;
    logic [PW-1:0]         r_prod;
    logic [MCW-1:0]        r_cnt;
    logic [MW:0]           r_rem;
    logic [PHASE_BITS-1:0] r_phase;
    logic signed [17:0]    r_w;
    logic signed [34:0]    r_x;

    logic [17:0]  rate_eff;
    logic [MW:0]  rem_sh;
    logic [MW:0]  div_sh;
    logic [14:0]  q;
    logic [12:0]  pos;
    logic [13:0]  spos;
    logic [16:0]  qs_i;
    logic [16:0]  qs_n;
    logic [18:0]  qs_d;
    logic signed [17:0] wave;
    logic [34:0]  mag;
    logic [5:0]   ti;
    logic [15:0]  tf;
    logic [14:0]  t0;
    logic [14:0]  t1;
    logic [31:0]  tprod;
    logic [15:0]  tv;
    logic [14:0]  tmag;
    logic [SAMPLE_BITS-1:0] smag;

    assign rate_eff = (i_sample_rate == 18'd0) ? 18'd1 : i_sample_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else if (i_cmd.load) begin
            r_index <= (i_first ? '0 : r_index) + 1'b1;
        end
    end

    // product is reduced mod m bit-serially from the top
    assign rem_sh = {r_rem[MW-1:0], r_prod[PW-1]};
    assign div_sh = {r_rem[MW-1:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx  <= i_first ? '0 : r_index;
            r_freq <= i_frequency;
            r_m    <= {rate_eff, 8'd0};
            r_prod <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.mul_step) begin
            // one index bit per cycle, MSB first
            r_prod <= {r_prod[PW-2:0], 1'b0}
                      + (r_idx[INDEX_BITS-1] ? PW'(r_freq) : PW'(0));
            r_idx  <= {r_idx[INDEX_BITS-2:0], 1'b0};
            r_cnt  <= (r_cnt == MCW'(INDEX_BITS - 1)) ? '0 : r_cnt + 1'b1;
            r_rem  <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem  <= (rem_sh >= {1'b0, r_m}) ? rem_sh - {1'b0, r_m} : rem_sh;
            r_prod <= {r_prod[PW-2:0], 1'b0};
            // wraps to zero on the last step, ready for the divide
            r_cnt  <= (r_cnt == MCW'(PW - 1)) ? '0 : r_cnt + 1'b1;
        end else if (i_cmd.div_step) begin
            // restoring division of rem*2^PHASE_BITS by m
            r_rem   <= (div_sh >= {1'b0, r_m}) ? div_sh - {1'b0, r_m} : div_sh;
            r_phase <= {r_phase[PHASE_BITS-2:0], div_sh >= {1'b0, r_m}};
            r_cnt   <= r_cnt + 1'b1;
        end
        if (i_cmd.shape) r_w <= wave;
        if (i_cmd.clip) r_x <= 35'(r_w) * 35'($signed({1'b0, i_amp_gain}));
    end

    assign o_status.mul_done = i_cmd.mul_step && (r_cnt == MCW'(INDEX_BITS - 1));
    assign o_status.mod_done = i_cmd.mod_step && (r_cnt == MCW'(PW - 1));
    assign o_status.div_done = i_cmd.div_step && (r_cnt[DCW-1:0] == DCW'(PHASE_BITS - 1));

    generate
        if (SH >= 0) begin : g_qr
            assign q = r_phase[SH +: 15];
        end else begin : g_ql
            assign q = 15'({r_phase, {(-SH){1'b0}}});
        end
    endgenerate

    always_comb begin
        pos  = q[12:0];
        spos = q[13] ? 14'd8192 - {1'b0, pos} : {1'b0, pos};
        qs_i = {1'b0, sine_tab({1'b0, spos[12:8]})};
        qs_n = {1'b0, sine_tab({1'b0, spos[12:8]} + 6'd1)};
        qs_d = 19'(qs_n - qs_i) * 19'(spos[7:0]);
        if (spos[13]) begin
            qs_i = 17'd32768;
        end else begin
            qs_i = qs_i + {6'd0, qs_d[18:8]};
        end
        wave = 18'sd0;
        case (i_wave_shape)
            SHAPE_SINE:   wave = q[14] ? -$signed({1'b0, qs_i}) : $signed({1'b0, qs_i});
            SHAPE_SQUARE: wave = (r_phase != '0 && !r_phase[PHASE_BITS-1])
                                 ? 18'sd32768 : -18'sd32768;
            SHAPE_SAWTOOTH: wave = $signed({2'b0, q, 1'b0}) - 18'sd32768;
            default: wave = !q[14] ? $signed({1'b0, q, 2'b0}) - 18'sd32768
                                  : 18'sd98304 - $signed({1'b0, q, 2'b0});
        endcase
    end

    always_comb begin
        mag   = r_x[34] ? 35'(-r_x) : 35'(r_x);
        ti    = (mag[34:24] >= 11'd44) ? 6'd44 : 6'(mag[29:24]);
        tf    = mag[23:8];
        t0    = tanh_tab(ti);
        t1    = tanh_tab(ti + 6'd1);
        tprod = 32'(t1 - t0) * 32'(tf);
        tv    = (mag[34:24] >= 11'd44) ? 16'd32767 : 16'(t0) + 16'(tprod[31:16]);
        tmag  = tv[15] ? 15'd32767 : tv[14:0];
        if (SAMPLE_BITS >= 16)
            smag = SAMPLE_BITS'({tmag, {(SAMPLE_BITS>16 ? SAMPLE_BITS-16 : 1){1'b0}}}
                                >> (SAMPLE_BITS>16 ? 0 : 1));
        else smag = SAMPLE_BITS'(tmag >> (16 - SAMPLE_BITS));
    end

    // output sample taken from the registered product
    assign o_sample = r_x[34] ? SAMPLE_BITS'(-smag) : smag;
endmodule
`default_nettype wire

// ===== rtl/core/multi_waveform_oscillator_unit.sv =====
// Top level: oscillator with configuration registers, controller and datapath.
//
// Usage:
//   Slave stream: s_axis_tdata carries frequency (unsigned Q24.8 Hz), s_axis_tuser
//   carries the first flag, which restarts the sample index at zero.
//   Master stream: m_axis_tdata carries one signed Q1.15 sample per input word.
//   Configuration: i_cfg_we/i_cfg_idx/i_cfg_data; index 0 wave shape,
//   1 sample rate, 2 amplitude gain. Write only while idle.
//   Sequence: shift-add multiply over the INDEX_BITS index bits, modular
//   reduction over the 32+INDEX_BITS product bits, phase division over the
//   PHASE_BITS quotient bits, then a wave step and a multiply/clip step,
//   after which m_axis_tvalid rises. One word at a time: a new word is not
//   taken until the last result is taken; the bit-serial loops, the
//   reduction most, set the time each word takes.
//   The result waits in the output register while the receiver stalls; a new
//   word is accepted in the same cycle the result is taken.
//   Reset (synchronous, active low) restores register defaults and clears the
//   sample index.
`default_nettype none
module multi_waveform_oscillator_unit #(
    parameter int INDEX_BITS  = 32,
    parameter int PHASE_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire [31:0]                   s_axis_tdata,  // [31:0] frequency
    input  wire                          s_axis_tuser,  // [0] first
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata, // [SAMPLE_BITS-1:0] sample
    input  wire                          i_cfg_we,
    input  wire [mwo_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [mwo_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mwo_pkg::*;

    localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;

    logic [1:0]  r_wave_shape;
    logic [17:0] r_sample_rate;
    logic [15:0] r_amp_gain;
    t_cmd        cmd;
    t_status     status;
    logic [SAMPLE_BITS-1:0] sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape  <= SHAPE_SINE;
            r_sample_rate <= 18'd48000;
            r_amp_gain    <= 16'd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WAVE_SHAPE:  r_wave_shape  <= i_cfg_data[1:0];
                REG_SAMPLE_RATE: r_sample_rate <= i_cfg_data;
                REG_AMP_GAIN:    r_amp_gain    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    mwo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mwo_dp #(
        .INDEX_BITS  (INDEX_BITS),
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_frequency  (s_axis_tdata),
        .i_first      (s_axis_tuser),
        .i_wave_shape (r_wave_shape),
        .i_sample_rate(r_sample_rate),
        .i_amp_gain   (r_amp_gain),
        .o_sample     (sample)
    );

    assign m_axis_tdata = TDW'(sample);
endmodule
`default_nettype wire
